/* design/bres_pkg.sv */
// Shared types, constants and helpers for the line rasterizer.
package bres_pkg;

  // Width of the decision field on the result stream
  localparam int DEC_W = 8;

  // Status that the setup queue reports to both of its sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Round a bit count up to whole bytes
  function automatic int pad_bytes(input int nbits);
    return ((nbits + 7) / 8) * 8;
  endfunction

endpackage

/* design/bres_front.sv */
// Front end: accepts line requests and computes the per-line stepping setup.
module bres_front #(
  parameter int COORD_BITS = 6,
  parameter int ENTRY_W    = 6 * COORD_BITS + 9
) (
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COORD_BITS-1:0] start_x,
  input  logic [COORD_BITS-1:0] start_y,
  input  logic [COORD_BITS-1:0] end_x,
  input  logic [COORD_BITS-1:0] end_y,
  input  bres_pkg::q_status_t   q_status,
  output logic                  push,
  output logic [ENTRY_W-1:0]    entry
);

  localparam int DW = COORD_BITS + 2;

  logic [COORD_BITS-1:0] adx, ady, maj, mnr;
  logic                  x_dec, y_dec, x_major;
  logic signed [DW-1:0]  d0, inc_keep, inc_move;

  // Distances and directions
  always_comb begin
    x_dec   = end_x < start_x;
    y_dec   = end_y < start_y;
    adx     = x_dec ? (start_x - end_x) : (end_x - start_x);
    ady     = y_dec ? (start_y - end_y) : (end_y - start_y);
    x_major = adx >= ady;
    maj     = x_major ? adx : ady;
    mnr     = x_major ? ady : adx;
  end

  // Initial decision value and the two increments
  always_comb begin
    inc_keep = signed'({1'b0, mnr, 1'b0});
    inc_move = signed'({1'b0, mnr, 1'b0}) - signed'({1'b0, maj, 1'b0});
    d0       = signed'({1'b0, mnr, 1'b0}) - signed'({2'b00, maj});
  end

  assign in_ready = !q_status.full;
  assign push     = in_valid && in_ready;
  assign entry    = {start_x, start_y, x_dec, y_dec, x_major, maj, d0, inc_keep, inc_move};

endmodule

/* design/bres_queue.sv */
// Two-entry queue that holds line setups between front and back end.
module bres_queue #(
  parameter int W = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  logic [W-1:0]        wdata,
  input  logic                pop,
  output logic [W-1:0]        rdata,
  output bres_pkg::q_status_t status
);

  logic [W-1:0] slot_r [2];
  logic         wr_ptr_r, rd_ptr_r;
  logic [1:0]   count_r;

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= wdata;
  end

  assign rdata        = slot_r[rd_ptr_r];
  assign status.full  = count_r == 2'd2;
  assign status.empty = count_r == 2'd0;

endmodule

/* design/bres_back.sv */
// Back end: walks one line a pixel per cycle, while the output is not stalled, into a registered output.
module bres_back #(
  parameter int COORD_BITS = 6,
  parameter int ENTRY_W    = 6 * COORD_BITS + 9
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bres_pkg::q_status_t          q_status,
  input  logic [ENTRY_W-1:0]           entry,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [COORD_BITS-1:0]        pixel_x,
  output logic [COORD_BITS-1:0]        pixel_y,
  output logic [bres_pkg::DEC_W-1:0]   decision,
  output logic                         last_pixel
);

  localparam int DW = COORD_BITS + 2;

  // Unpacked setup
  logic [COORD_BITS-1:0] e_x0, e_y0, e_maj;
  logic                  e_x_dec, e_y_dec, e_x_major;
  logic signed [DW-1:0]  e_d0, e_keep, e_move;

  assign {e_x0, e_y0, e_x_dec, e_y_dec, e_x_major, e_maj, e_d0, e_keep, e_move} = entry;

  // Walk state
  logic                  busy_r;
  logic [COORD_BITS-1:0] x_r, y_r, rem_r;
  logic                  x_dec_r, y_dec_r, x_major_r;
  logic signed [DW-1:0]  d_r, keep_r, move_r;

  // Output register
  logic                       out_valid_r, last_r;
  logic [COORD_BITS-1:0]      px_r, py_r;
  logic [bres_pkg::DEC_W-1:0] dec_r;

  logic                  emit, minor_move;
  logic [COORD_BITS-1:0] x_nxt, y_nxt, x_adj, y_adj;
  logic signed [DW-1:0]  d_nxt;
  logic signed [31:0]    d_ext;

  assign pop  = !busy_r && !q_status.empty;
  assign emit = busy_r && (!out_valid_r || out_ready);

  // One Bresenham step from the current pixel
  always_comb begin
    minor_move = !d_r[DW-1];
    d_nxt      = minor_move ? (d_r + move_r) : (d_r + keep_r);
    x_adj      = x_dec_r ? (x_r - 1'b1) : (x_r + 1'b1);
    y_adj      = y_dec_r ? (y_r - 1'b1) : (y_r + 1'b1);
    x_nxt      = (x_major_r || minor_move) ? x_adj : x_r;
    y_nxt      = (!x_major_r || minor_move) ? y_adj : y_r;
    d_ext      = 32'(d_r);
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop)            busy_r <= 1'b1;
      else if (emit)      busy_r <= rem_r != '0;
      if (emit)           out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (pop) begin
      x_r       <= e_x0;
      y_r       <= e_y0;
      d_r       <= e_d0;
      rem_r     <= e_maj;
      x_dec_r   <= e_x_dec;
      y_dec_r   <= e_y_dec;
      x_major_r <= e_x_major;
      keep_r    <= e_keep;
      move_r    <= e_move;
    end else if (emit) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      d_r   <= d_nxt;
      rem_r <= rem_r - 1'b1;
    end
    if (emit) begin
      px_r   <= x_r;
      py_r   <= y_r;
      dec_r  <= d_ext[bres_pkg::DEC_W-1:0];
      last_r <= rem_r == '0;
    end
  end

  assign out_valid  = out_valid_r;
  assign pixel_x    = px_r;
  assign pixel_y    = py_r;
  assign decision   = dec_r;
  assign last_pixel = last_r;

endmodule

/* design/bresenham_line_rasterizer.sv */
// Top level of the Bresenham line rasterizer.
// Usage:
//   Input stream (in_*): one beat is one line request, start and end point.
//   Output stream (out_*): one beat per pixel, start point first, end point
//   last with out_tlast high; covers all octants, both endpoints included.
// First pixel: when the output is free, a request goes into the setup queue,
//   is popped into the walker, then the first pixel enters the output register.
// Walker: a line of major distance M gives M + 1 pixels. The walker loads the
//   setup, then advances one pixel per cycle while the output is not stalled;
//   it pops the next setup only once the current line is done.
// A two-entry setup queue lets requests be taken while a line is drawn;
//   in_tready drops only when that queue is full.
// Receiver stall: the pixel walker holds its position while a pixel is pending
//   and out_tready is low; the pending pixel stays registered on out_tdata.
// Reset (rst_n low, synchronous): queue emptied, walker idle, no output beat.
module bresenham_line_rasterizer #(
  parameter int COORD_BITS = 6
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // start_x, start_y, end_x, end_y from bit 0 up, zero filled to bytes
  input  logic [bres_pkg::pad_bytes(4*COORD_BITS)-1:0] in_tdata,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  // pixel_x, pixel_y, decision from bit 0 up, zero filled to bytes
  output logic [bres_pkg::pad_bytes(2*COORD_BITS+bres_pkg::DEC_W)-1:0] out_tdata,
  output logic                    out_tlast,
  output logic                    out_tvalid,
  input  logic                    out_tready
);

  localparam int ENTRY_W = 6 * COORD_BITS + 9;
  localparam int C       = COORD_BITS;
  localparam int OUT_W   = bres_pkg::pad_bytes(2 * COORD_BITS + bres_pkg::DEC_W);

  bres_pkg::q_status_t        q_status;
  logic                       push, pop;
  logic [ENTRY_W-1:0]         wr_entry, rd_entry;
  logic [C-1:0]               pixel_x, pixel_y;
  logic [bres_pkg::DEC_W-1:0] decision;

  bres_front #(.COORD_BITS(COORD_BITS), .ENTRY_W(ENTRY_W)) u_front (
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .start_x  (in_tdata[C-1:0]),
    .start_y  (in_tdata[2*C-1:C]),
    .end_x    (in_tdata[3*C-1:2*C]),
    .end_y    (in_tdata[4*C-1:3*C]),
    .q_status (q_status),
    .push     (push),
    .entry    (wr_entry)
  );

  bres_queue #(.W(ENTRY_W)) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wdata  (wr_entry),
    .pop    (pop),
    .rdata  (rd_entry),
    .status (q_status)
  );

  bres_back #(.COORD_BITS(COORD_BITS), .ENTRY_W(ENTRY_W)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_status   (q_status),
    .entry      (rd_entry),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .decision   (decision),
    .last_pixel (out_tlast)
  );

  // Pack the pixel beat
  assign out_tdata = OUT_W'({decision, pixel_y, pixel_x});

endmodule

/* design/bres_checker.sv */
// Port-level assertions for the line rasterizer, bound to the top level.
module bres_checker #(
  parameter int COORD_BITS = 6
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    out_tvalid,
  input logic                    out_tready,
  input logic [2*COORD_BITS-1:0] out_xy,
  input logic                    out_tlast
);

  logic                  have_prev_r;
  logic [COORD_BITS-1:0] prev_x_r, prev_y_r;
  logic                  out_beat, adjacent;
  logic [COORD_BITS-1:0] cur_x, cur_y, dx, dy;

  assign out_beat = out_tvalid && out_tready;
  assign cur_x    = out_xy[COORD_BITS-1:0];
  assign cur_y    = out_xy[2*COORD_BITS-1:COORD_BITS];
  assign dx       = cur_x - prev_x_r;
  assign dy       = cur_y - prev_y_r;
  // Within a line each coordinate moves by at most one, and never both stay
  assign adjacent = ((dx == '0) || (dx == 1) || (dx == '1)) &&
                    ((dy == '0) || (dy == 1) || (dy == '1)) &&
                    !((dx == '0) && (dy == '0));

  // Track the previous pixel beat of the current line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r <= 1'b0;
    end else if (out_beat) begin
      have_prev_r <= !out_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (out_beat) begin
      prev_x_r <= cur_x;
      prev_y_r <= cur_y;
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output beat presented right after reset");

  a_pixel_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_beat && have_prev_r |-> adjacent)
    else $error("consecutive pixels of a line are not neighbors");

endmodule

bind bresenham_line_rasterizer bres_checker #(.COORD_BITS(COORD_BITS)) u_bres_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_xy     (out_tdata[2*COORD_BITS-1:0]),
  .out_tlast  (out_tlast)
);

/* dv/tb_top.sv */
// Self-checking testbench for the line rasterizer: random and corner-case line requests.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_BITS = 6;
  localparam int COORD_MAX  = (1 << COORD_BITS) - 1;
  localparam int IN_W  = bres_pkg::pad_bytes(4*COORD_BITS);
  localparam int OUT_W = bres_pkg::pad_bytes(2*COORD_BITS + bres_pkg::DEC_W);
  localparam int RANDOM_LINES = 288;
  localparam int QUIET_TAIL   = 40;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 20;

  typedef logic [COORD_BITS-1:0] coord_t;

  // One pixel of a rasterized line
  typedef struct {
    coord_t                             x;
    coord_t                             y;
    logic signed [bres_pkg::DEC_W-1:0] decision;
    logic                               last;
  } pixel_t;

  // Line walker predictor plus the queue of pixels still due
  class line_scoreboard;
    pixel_t pixels_due[$];
    int     errors = 0;

    function void note_request(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
      int adx, ady, stx, sty, major, minor, d, x, y, count;
      bit x_major;
      pixel_t p;
      adx = (sx > ex) ? (sx - ex) : (ex - sx);
      ady = (sy > ey) ? (sy - ey) : (ey - sy);
      stx = (ex > sx) ? 1 : ((ex < sx) ? -1 : 0);
      sty = (ey > sy) ? 1 : ((ey < sy) ? -1 : 0);
      x_major = (adx >= ady);
      major = x_major ? adx : ady;
      minor = x_major ? ady : adx;
      d = 2*minor - major;
      x = sx;
      y = sy;
      count = major + 1;
      for (int k = 0; k < count; k++) begin
        if (k > 0) begin
          // tie (d == 0) moves the minor axis
          if (d < 0) begin
            d += 2*minor;
          end else begin
            d += 2*minor - 2*major;
            if (x_major) y += sty;
            else x += stx;
          end
          if (x_major) x += stx;
          else y += sty;
        end
        p.x = coord_t'(x);
        p.y = coord_t'(y);
        p.decision = d[bres_pkg::DEC_W-1:0];
        p.last = (k == count - 1);
        pixels_due.push_back(p);
      end
    endfunction

    function void check_pixel(coord_t x, coord_t y,
                              logic signed [bres_pkg::DEC_W-1:0] decision, logic last);
      pixel_t p;
      if (pixels_due.size() == 0) begin
        $error("pixel beat with none due: x=%0d y=%0d", x, y);
        errors++;
        return;
      end
      p = pixels_due.pop_front();
      if (x !== p.x) begin
        $error("pixel_x expected %0d actual %0d", p.x, x);
        errors++;
      end
      if (y !== p.y) begin
        $error("pixel_y expected %0d actual %0d", p.y, y);
        errors++;
      end
      if (decision !== p.decision) begin
        $error("decision expected %0d actual %0d", p.decision, decision);
        errors++;
      end
      if (last !== p.last) begin
        $error("last_pixel expected %0d actual %0d", p.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return pixels_due.size();
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic [IN_W-1:0]  in_tdata;
  logic             in_tvalid;
  logic             in_tready;
  logic [OUT_W-1:0] out_tdata;
  logic             out_tlast;
  logic             out_tvalid;
  logic             out_tready;

  line_scoreboard sb;
  int stall_pct;
  int cycles = 0;

  bresenham_line_rasterizer #(.COORD_BITS(COORD_BITS)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Cycle counter and timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("bresenham_line_rasterizer test failed");
      $finish;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_pixel(out_tdata[COORD_BITS-1:0],
                     out_tdata[2*COORD_BITS-1:COORD_BITS],
                     out_tdata[2*COORD_BITS+bres_pkg::DEC_W-1:2*COORD_BITS],
                     out_tlast);
  end

  // Receiver back-pressure in random bursts
  initial begin
    int n;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 99) < stall_pct) begin
        out_tready <= 1'b0;
        n = $urandom_range(1, 7);
        repeat (n - 1) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Drive one line request and wait for its beat
  task automatic send_line(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
    @(negedge clk);
    in_tdata  <= {ey, ex, sy, sx};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_request(sx, sy, ex, ey);
  endtask

  // Random sender gap with in_tvalid low, taken at the current stall rate
  task automatic maybe_gap();
    int n;
    if ($urandom_range(0, 99) < stall_pct) begin
      n = $urandom_range(1, 7);
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  function automatic coord_t near_coord(coord_t c);
    int v;
    v = int'(c) + $urandom_range(0, 6) - 3;
    if (v < 0) v = 0;
    if (v > COORD_MAX) v = COORD_MAX;
    return coord_t'(v);
  endfunction

  function automatic coord_t edge_coord();
    int pick;
    pick = $urandom_range(0, 2);
    if (pick == 0) return '0;
    if (pick == 1) return coord_t'(COORD_MAX);
    return coord_t'($urandom_range(0, COORD_MAX));
  endfunction

  // Main sequence
  initial begin
    coord_t sx, sy, ex, ey;
    int kind;
    sb = new();
    stall_pct = 0;
    rst_n = 1'b0;
    in_tdata = '0;
    in_tvalid = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: single points, full-length axes, diagonals, ties, every octant
    stall_pct = 20;
    send_line(0, 0, 0, 0);
    send_line(63, 63, 63, 63);
    send_line(0, 0, 63, 0);
    send_line(63, 0, 0, 0);
    send_line(0, 0, 0, 63);
    send_line(0, 63, 0, 0);
    send_line(0, 0, 63, 63);
    send_line(63, 63, 0, 0);
    send_line(0, 63, 63, 0);
    send_line(63, 0, 0, 63);
    send_line(0, 0, 2, 1);
    send_line(0, 0, 1, 2);
    send_line(10, 10, 20, 14);
    send_line(10, 10, 14, 20);
    send_line(10, 10, 6, 20);
    send_line(10, 10, 0, 14);
    send_line(10, 10, 0, 6);
    send_line(10, 10, 6, 0);
    send_line(10, 10, 14, 0);
    send_line(10, 10, 20, 6);
    send_line(42, 21, 43, 21);
    send_line(21, 42, 21, 41);

    // Random: mostly arbitrary lines, some short, some on the borders
    for (int i = 0; i < RANDOM_LINES; i++) begin
      if (i % 50 == 0) begin
        kind = $urandom_range(0, 2);
        stall_pct = (kind == 0) ? 0 : ((kind == 1) ? 15 : 45);
      end
      if (i >= RANDOM_LINES - QUIET_TAIL) stall_pct = 0;
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        sx = coord_t'($urandom_range(0, COORD_MAX));
        sy = coord_t'($urandom_range(0, COORD_MAX));
        ex = coord_t'($urandom_range(0, COORD_MAX));
        ey = coord_t'($urandom_range(0, COORD_MAX));
      end else if (kind < 85) begin
        sx = coord_t'($urandom_range(0, COORD_MAX));
        sy = coord_t'($urandom_range(0, COORD_MAX));
        ex = near_coord(sx);
        ey = near_coord(sy);
      end else begin
        sx = edge_coord();
        sy = edge_coord();
        ex = edge_coord();
        ey = edge_coord();
      end
      maybe_gap();
      send_line(sx, sy, ex, ey);
    end
    @(negedge clk);
    in_tvalid <= 1'b0;

    // Drain, then a short settle for any stray beat
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("bresenham_line_rasterizer test passed");
    end else begin
      $display("bresenham_line_rasterizer test failed");
    end
    $finish;
  end

endmodule
